>>> hdl/tcw_pkg.sv
package tcw_pkg;

    localparam logic [1:0] FUNC_PUT   = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] SPACE_CODE   = 8'd32;
    localparam logic [7:0] RESET_COLOR  = 8'd7;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  char_code;
        logic [10:0] cell_index;
    } req_t;

    typedef struct packed {
        logic [15:0] cell_word;
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
        logic        scrolled;
    } rsp_t;

endpackage

>>> hdl/text_console_writer.sv
// Text console writer: a screen of ROWS x COLUMNS cells, each holding a
// character in the low byte and its colour in the high byte.
// Channels: req (valid/ready) carries put, read and clear requests; rsp
// (valid/ready) returns one result per request with the cursor after it;
// cfg (valid/ready, always ready) writes the colour used for new cells.
// Operations:
//   put of a character or newline without scroll, unused code: done on
//     acceptance; such requests can be taken in every cycle unless rsp stalls.
//   read of one cell: the result waits for the registered memory read.
//   put that scrolls: the memory's single write port copies
//     each row up one cell per cycle, then blanks the bottom row.
//   clear: one cell written per cycle.
// Reset homes the cursor, sets the colour to 7 and then runs a clearing
// pass over the memory; req_ready stays low meanwhile.
// A result waits in the rsp register while the receiver stalls; a new
// request is taken only when that register is free or being emptied.
module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  tcw_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output tcw_pkg::rsp_t rsp,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [7:0]    cfg_data
);

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = $clog2(CELLS + 1);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);

    typedef enum logic [5:0] {
        ST_INIT   = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_READ   = 6'b000100,
        ST_SCROLL = 6'b001000,
        ST_FILL   = 6'b010000,
        ST_CLEAR  = 6'b100000
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [COL_W-1:0]   col_reg;
    logic [7:0]         color_reg;
    logic               rsp_valid_reg;
    logic               rd_ok_reg;
    tcw_pkg::rsp_t      pend_reg;
    tcw_pkg::rsp_t      rsp_reg;
    logic [15:0]        rd_data_reg;

    logic [15:0]        screen_mem [CELLS];

    logic               acc;
    logic               is_nl;
    logic [COL_W:0]     col_inc;
    logic               wrap;
    logic               adv_row;
    logic               at_bottom;
    logic               scroll_c;
    logic [ROW_W-1:0]   row_nx;
    logic [COL_W-1:0]   col_nx;
    logic [31:0]        row_ext;
    logic [31:0]        col_ext;
    logic [31:0]        idx_ext;
    logic               idx_ok;
    tcw_pkg::rsp_t      res_c;
    logic               rsp_load;
    tcw_pkg::rsp_t      rsp_next;
    logic [ADDR_W-1:0]  put_addr;
    logic [CNT_W-1:0]   copy_dst;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_wa;
    logic [15:0]        mem_wd;
    logic [ADDR_W-1:0]  mem_ra;

    assign cfg_ready = 1'b1;
    assign req_ready = (state_reg == ST_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign acc       = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Cursor arithmetic for the request at the port.
    assign is_nl     = (req.char_code == tcw_pkg::NEWLINE_CODE);
    assign col_inc   = {1'b0, col_reg} + (COL_W + 1)'(1);
    assign wrap      = (col_inc == (COL_W + 1)'(COLUMNS));
    assign adv_row   = (req.func == tcw_pkg::FUNC_PUT) && (is_nl || wrap);
    assign at_bottom = (row_reg == ROW_W'(ROWS - 1));
    assign scroll_c  = adv_row && at_bottom;
    assign put_addr  = ADDR_W'(row_reg) * ADDR_W'(COLUMNS) + ADDR_W'(col_reg);
    assign idx_ext   = 32'(req.cell_index);
    assign idx_ok    = (idx_ext < 32'(CELLS));
    assign copy_dst  = cnt_reg - CNT_W'(COLUMNS + 1);

    always_comb
    begin
        row_nx = row_reg;
        col_nx = col_reg;
        unique case (req.func)
            tcw_pkg::FUNC_PUT:
            begin
                if (adv_row && !at_bottom)
                begin
                    row_nx = row_reg + ROW_W'(1);
                end
                col_nx = (is_nl || wrap) ? '0 : col_inc[COL_W-1:0];
            end
            tcw_pkg::FUNC_CLEAR:
            begin
                row_nx = '0;
                col_nx = '0;
            end
            default:
            begin
                row_nx = row_reg;
                col_nx = col_reg;
            end
        endcase
    end

    assign row_ext = 32'(row_nx);
    assign col_ext = 32'(col_nx);

    always_comb
    begin
        res_c.cell_word  = '0;
        res_c.cursor_row = row_ext[4:0];
        res_c.cursor_col = col_ext[6:0];
        res_c.scrolled   = scroll_c;
    end

    // Result loading: straight from the port for requests done on acceptance,
    // otherwise from the pending copy when the sweep or read finishes.
    always_comb
    begin
        rsp_load = 1'b0;
        rsp_next = pend_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                rsp_next = res_c;
                rsp_load = acc && (req.func != tcw_pkg::FUNC_READ)
                    && (req.func != tcw_pkg::FUNC_CLEAR) && !scroll_c;
            end
            ST_READ:
            begin
                rsp_load = 1'b1;
                rsp_next.cell_word = rd_ok_reg ? rd_data_reg : '0;
            end
            ST_FILL, ST_CLEAR:
            begin
                rsp_load = (cnt_reg == CNT_W'(CELLS - 1));
            end
            default:
            begin
                rsp_load = 1'b0;
            end
        endcase
    end

    // Memory port selection.
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = cnt_reg[ADDR_W-1:0];
        mem_wd = {color_reg, tcw_pkg::SPACE_CODE};
        mem_ra = cnt_reg[ADDR_W-1:0];
        unique case (state_reg)
            ST_INIT:
            begin
                mem_we = 1'b1;
                mem_wd = {tcw_pkg::RESET_COLOR, tcw_pkg::SPACE_CODE};
            end
            ST_IDLE:
            begin
                mem_ra = idx_ext[ADDR_W-1:0];
                mem_wa = put_addr;
                mem_wd = {color_reg, req.char_code};
                mem_we = acc && (req.func == tcw_pkg::FUNC_PUT) && !is_nl;
            end
            ST_SCROLL:
            begin
                // Read data holds the cell at the previous count; it
                // moves one row up.
                mem_wa = copy_dst[ADDR_W-1:0];
                mem_wd = rd_data_reg;
                mem_we = (cnt_reg > CNT_W'(COLUMNS));
            end
            ST_FILL, ST_CLEAR:
            begin
                mem_we = 1'b1;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            screen_mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= screen_mem[mem_ra];
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            pend_reg <= res_c;
        end
        if (rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            cnt_reg       <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            color_reg     <= tcw_pkg::RESET_COLOR;
            rsp_valid_reg <= 1'b0;
            rd_ok_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                color_reg <= cfg_data;
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_INIT:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(CELLS - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (acc)
                    begin
                        row_reg   <= row_nx;
                        col_reg   <= col_nx;
                        rd_ok_reg <= idx_ok;
                        if (req.func == tcw_pkg::FUNC_READ)
                        begin
                            state_reg <= ST_READ;
                        end
                        else if (req.func == tcw_pkg::FUNC_CLEAR)
                        begin
                            state_reg <= ST_CLEAR;
                            cnt_reg   <= '0;
                        end
                        else if (scroll_c)
                        begin
                            state_reg <= ST_SCROLL;
                            cnt_reg   <= CNT_W'(COLUMNS);
                        end
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_IDLE;
                end
                ST_SCROLL:
                begin
                    if (cnt_reg == CNT_W'(CELLS))
                    begin
                        state_reg <= ST_FILL;
                        cnt_reg   <= CNT_W'(CELLS - COLUMNS);
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                ST_FILL, ST_CLEAR:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(CELLS - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
